/* sv/gvm_pkg.sv */
// gvm_pkg: shared widths, constants and controller/datapath interface types
// for the greedy vertex matching block. No dependencies.

package gvm_pkg;

  // field widths
  localparam int unsigned ID_W  = 10;
  localparam int unsigned WT_W  = 16;
  localparam int unsigned SUM_W = 17;
  localparam int unsigned CNT_W = 11;

  // default node count (depth of the matched map)
  localparam int unsigned NODE_COUNT_DEF = 1024;

  // coarse counter saturation value and weight limit after reset
  localparam logic [CNT_W-1:0] CNT_MAX    = 11'h7FF;
  localparam logic [SUM_W-1:0] MAXW_RESET = 17'h1FFFF;

  // commands from controller to datapath
  typedef struct packed {
    logic latch;   // edge beat accepted: capture fields
    logic clear;   // clear beat accepted: reset counter and run state
    logic sweep;   // clearing pass, one map entry per cycle
    logic eval;    // map read data valid: evaluate the beat
    logic write2;  // mark the partner entry
  } ctl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic sweep_done;   // last map entry is being cleared
    logic need_write2;  // beat closes an unmatched node's run
  } ctl_sts_t;

endpackage

/* sv/gvm_mod.sv */
// gvm_mod: reduces a node id modulo the map depth, two registered stages for
// depths below the id range, one register otherwise. Uses gvm_pkg.

module gvm_mod #(
  parameter int unsigned NODE_COUNT = gvm_pkg::NODE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic [gvm_pkg::ID_W-1:0]      id_i,
  output logic [$clog2(NODE_COUNT)-1:0] idx_o
);

  localparam int unsigned AW = $clog2(NODE_COUNT);

  logic [AW-1:0] idx_r;

  generate
    if (NODE_COUNT >= (1 << gvm_pkg::ID_W)) begin : g_direct
      // every id is already a valid index
      always_ff @(posedge clk) begin
        idx_r <= AW'(id_i);
      end
    end else begin : g_reduce
      // quotient by reciprocal, exact for 10-bit ids and depths up to 1024
      localparam int unsigned SH    = 2 * gvm_pkg::ID_W;
      localparam int unsigned RECIP = ((1 << SH) + NODE_COUNT - 1) / NODE_COUNT;
      localparam int unsigned PW    = SH + gvm_pkg::ID_W;

      logic [gvm_pkg::ID_W-1:0] q_r;
      logic [PW-1:0]            qprod;
      logic [SH-1:0]            back;
      logic [SH-1:0]            rem;

      assign qprod = PW'(id_i) * PW'(RECIP);

      // stage 2: remainder = id - q * depth
      assign back = SH'(q_r) * SH'(NODE_COUNT);
      assign rem  = SH'(id_i) - back;

      always_ff @(posedge clk) begin
        q_r   <= qprod[PW-1:SH];
        idx_r <= rem[AW-1:0];
      end
    end
  endgenerate

  assign idx_o = idx_r;

endmodule

/* sv/gvm_ctrl.sv */
// gvm_ctrl: sequencing state machine for the greedy vertex matching block.
// Uses gvm_pkg command/status types; drives the datapath in gvm_dp.

module gvm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_action,
  input  gvm_pkg::ctl_sts_t sts_i,
  output gvm_pkg::ctl_cmd_t cmd_o,
  output logic              busy
);

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_QUOT,
    ST_INDEX,
    ST_READ,
    ST_EVAL,
    ST_WRITE2
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   accept;

  assign accept = start && !busy_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP:  if (sts_i.sweep_done) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) state_nxt = in_action ? ST_SWEEP : ST_QUOT;
      end
      ST_QUOT:   state_nxt = ST_INDEX;
      ST_INDEX:  state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_EVAL;
      ST_EVAL:   state_nxt = sts_i.need_write2 ? ST_WRITE2 : ST_IDLE;
      ST_WRITE2: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
    busy_nxt = (state_nxt != ST_IDLE);
  end

  // state and registered busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  // commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.latch  = accept && !in_action;
    cmd_o.clear  = accept && in_action;
    cmd_o.sweep  = (state_r == ST_SWEEP);
    cmd_o.eval   = (state_r == ST_EVAL);
    cmd_o.write2 = (state_r == ST_WRITE2);
  end

  assign busy = busy_r;

endmodule

/* sv/gvm_dp.sv */
// gvm_dp: datapath of the greedy vertex matching block: field capture, id
// reduction, matched map memory, run state and coarse counter.
// Uses gvm_pkg and gvm_mod.

module gvm_dp #(
  parameter int unsigned NODE_COUNT = gvm_pkg::NODE_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gvm_pkg::ctl_cmd_t           cmd_i,
  output gvm_pkg::ctl_sts_t           sts_o,
  input  logic                        cfg_we,
  input  logic [gvm_pkg::SUM_W-1:0]   cfg_wdata,
  input  logic [gvm_pkg::ID_W-1:0]    in_node_id,
  input  logic [gvm_pkg::WT_W-1:0]    in_node_weight,
  input  logic                        in_has_neighbor,
  input  logic [gvm_pkg::ID_W-1:0]    in_neighbor_id,
  input  logic [gvm_pkg::WT_W-1:0]    in_neighbor_weight,
  input  logic                        in_last_of_node,
  output logic                        out_valid,
  output logic [gvm_pkg::ID_W-1:0]    out_coarse_node,
  output logic [gvm_pkg::ID_W-1:0]    out_partner,
  output logic [gvm_pkg::ID_W-1:0]    out_coarse_index,
  output logic                        out_paired
);

  localparam int unsigned AW = $clog2(NODE_COUNT);
  localparam int unsigned IW = gvm_pkg::ID_W;

  // captured beat
  logic [IW-1:0]                node_r, nb_r;
  logic [gvm_pkg::WT_W-1:0]     nw_r, nbw_r;
  logic                         has_nb_r, last_r;

  // config
  logic [gvm_pkg::SUM_W-1:0]    max_weight_r;

  // run state and counter
  logic                         node_skipped_r, node_skipped_nxt;
  logic                         partner_found_r, partner_found_nxt;
  logic [IW-1:0]                chosen_partner_r, chosen_partner_nxt;
  logic                         mid_node_r, mid_node_nxt;
  logic [gvm_pkg::CNT_W-1:0]    coarse_count_r, coarse_count_nxt;
  logic [AW-1:0]                chosen_idx_r;
  logic [AW-1:0]                part_idx_r;
  logic [AW-1:0]                sweep_addr_r, sweep_addr_nxt;

  // map
  logic                         map_mem [NODE_COUNT];
  logic                         rd_node_r, rd_nb_r;
  logic [AW-1:0]                idx_node, idx_nb;
  logic                         map_we;
  logic [AW-1:0]                map_waddr;
  logic                         map_wdata;

  // evaluation
  logic                         skip_now, pf_prev, take, pf_now, emit;
  logic [IW-1:0]                cp_prev, cp_now;
  logic [AW-1:0]                cidx_now;
  logic [gvm_pkg::SUM_W-1:0]    wsum;
  logic                         sweep_done;

  // output registers
  logic                         out_valid_r;
  logic [IW-1:0]                out_coarse_node_r, out_partner_r, out_coarse_index_r;
  logic                         out_paired_r;

  // id reduction for both map addresses
  gvm_mod #(.NODE_COUNT(NODE_COUNT)) u_mod_node (
    .clk   (clk),
    .id_i  (node_r),
    .idx_o (idx_node)
  );

  gvm_mod #(.NODE_COUNT(NODE_COUNT)) u_mod_nb (
    .clk   (clk),
    .id_i  (nb_r),
    .idx_o (idx_nb)
  );

  // beat capture
  always_ff @(posedge clk) begin
    if (cmd_i.latch) begin
      node_r   <= in_node_id;
      nw_r     <= in_node_weight;
      has_nb_r <= in_has_neighbor;
      nb_r     <= in_neighbor_id;
      nbw_r    <= in_neighbor_weight;
      last_r   <= in_last_of_node;
    end
  end

  // matched map: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    rd_node_r <= map_mem[idx_node];
    rd_nb_r   <= map_mem[idx_nb];
  end

  // candidate test on the current beat
  always_comb begin
    skip_now = mid_node_r ? node_skipped_r : rd_node_r;
    pf_prev  = mid_node_r && partner_found_r;
    cp_prev  = mid_node_r ? chosen_partner_r : '0;
    wsum     = {1'b0, nw_r} + {1'b0, nbw_r};
    take     = !skip_now && !pf_prev && has_nb_r && (nb_r != node_r) &&
               !rd_nb_r && (wsum <= max_weight_r);
    pf_now   = pf_prev || take;
    cp_now   = take ? nb_r : cp_prev;
    cidx_now = take ? idx_nb : chosen_idx_r;
    emit     = cmd_i.eval && last_r && !skip_now;
  end

  assign sweep_done = (sweep_addr_r == AW'(NODE_COUNT - 1));

  // map write select
  always_comb begin
    map_we    = 1'b0;
    map_waddr = sweep_addr_r;
    map_wdata = 1'b0;
    if (cmd_i.sweep) begin
      map_we = 1'b1;
    end else if (emit) begin
      map_we    = 1'b1;
      map_waddr = idx_node;
      map_wdata = 1'b1;
    end else if (cmd_i.write2) begin
      map_we    = 1'b1;
      map_waddr = part_idx_r;
      map_wdata = 1'b1;
    end
  end

  // run state and counter next values
  always_comb begin
    node_skipped_nxt   = node_skipped_r;
    partner_found_nxt  = partner_found_r;
    chosen_partner_nxt = chosen_partner_r;
    mid_node_nxt       = mid_node_r;
    coarse_count_nxt   = coarse_count_r;
    sweep_addr_nxt     = sweep_addr_r;
    if (cmd_i.clear) begin
      node_skipped_nxt   = 1'b0;
      partner_found_nxt  = 1'b0;
      chosen_partner_nxt = '0;
      mid_node_nxt       = 1'b0;
      coarse_count_nxt   = '0;
    end else if (cmd_i.eval) begin
      if (last_r) begin
        node_skipped_nxt   = 1'b0;
        partner_found_nxt  = 1'b0;
        chosen_partner_nxt = '0;
        mid_node_nxt       = 1'b0;
        if (!skip_now && (coarse_count_r != gvm_pkg::CNT_MAX)) begin
          coarse_count_nxt = coarse_count_r + 1'b1;
        end
      end else begin
        node_skipped_nxt   = skip_now;
        partner_found_nxt  = pf_now;
        chosen_partner_nxt = cp_now;
        mid_node_nxt       = 1'b1;
      end
    end
    if (cmd_i.sweep) begin
      sweep_addr_nxt = sweep_done ? '0 : sweep_addr_r + 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_skipped_r   <= 1'b0;
      partner_found_r  <= 1'b0;
      chosen_partner_r <= '0;
      mid_node_r       <= 1'b0;
      coarse_count_r   <= '0;
      sweep_addr_r     <= '0;
      max_weight_r     <= gvm_pkg::MAXW_RESET;
      out_valid_r      <= 1'b0;
    end else begin
      node_skipped_r   <= node_skipped_nxt;
      partner_found_r  <= partner_found_nxt;
      chosen_partner_r <= chosen_partner_nxt;
      mid_node_r       <= mid_node_nxt;
      coarse_count_r   <= coarse_count_nxt;
      sweep_addr_r     <= sweep_addr_nxt;
      out_valid_r      <= emit;
      if (cfg_we) begin
        max_weight_r <= cfg_wdata;
      end
    end
  end

  // payload registers: partner index and result beat
  always_ff @(posedge clk) begin
    if (cmd_i.eval) begin
      chosen_idx_r <= cidx_now;
      part_idx_r   <= pf_now ? cidx_now : idx_node;
    end
    if (emit) begin
      out_coarse_node_r  <= node_r;
      out_partner_r      <= pf_now ? cp_now : node_r;
      out_coarse_index_r <= coarse_count_r[IW-1:0];
      out_paired_r       <= pf_now;
    end
  end

  always_comb begin
    sts_o             = '0;
    sts_o.sweep_done  = sweep_done;
    sts_o.need_write2 = last_r && !skip_now;
  end

  assign out_valid        = out_valid_r;
  assign out_coarse_node  = out_coarse_node_r;
  assign out_partner      = out_partner_r;
  assign out_coarse_index = out_coarse_index_r;
  assign out_paired       = out_paired_r;

`ifndef SYNTHESIS
  // result strobe lasts a single cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  // partner write only follows a delivered result
  a_write2_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.write2 |-> out_valid_r)
    else $error("partner write without a result beat");

  // an unpaired result names the node itself as its partner
  a_unpaired_self: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_paired_r) |-> (out_partner_r == out_coarse_node_r))
    else $error("unpaired result with a distinct partner");

  // clear beat resets counter and open run
  a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.clear |=> (coarse_count_r == '0) && !mid_node_r)
    else $error("clear did not reset counter or run state");
`endif

endmodule

/* sv/greedy_vertex_matching.sv */
// greedy_vertex_matching: top level of the greedy matching block for graph
// coarsening. Uses gvm_pkg, gvm_ctrl and gvm_dp (which holds gvm_mod).
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------
//   in      | start & !busy        | in_action, in_node_id, in_node_weight,
//           |                      | in_has_neighbor, in_neighbor_id,
//           |                      | in_neighbor_weight, in_last_of_node
//   out     | out_valid, 1 cycle   | out_coarse_node, out_partner,
//           |                      | out_coarse_index, out_paired
//   cfg     | cfg_we               | cfg_wdata (max_weight)
//
// An edge beat steps through ST_QUOT and ST_INDEX (id reduction, two registered
// stages for depths below the id range, one otherwise), ST_READ (registered map
// read) and ST_EVAL (evaluation); when it closes the run of an unmatched node,
// ST_WRITE2 adds a second map write for the partner on the single write port.
// A clear beat and reset both sweep the map one entry a cycle with busy high.
// The receiver cannot stall; each result is shown for exactly one cycle.

module greedy_vertex_matching #(
  parameter int unsigned NODE_COUNT = gvm_pkg::NODE_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_action,
  input  logic [gvm_pkg::ID_W-1:0]    in_node_id,
  input  logic [gvm_pkg::WT_W-1:0]    in_node_weight,
  input  logic                        in_has_neighbor,
  input  logic [gvm_pkg::ID_W-1:0]    in_neighbor_id,
  input  logic [gvm_pkg::WT_W-1:0]    in_neighbor_weight,
  input  logic                        in_last_of_node,
  output logic                        out_valid,
  output logic [gvm_pkg::ID_W-1:0]    out_coarse_node,
  output logic [gvm_pkg::ID_W-1:0]    out_partner,
  output logic [gvm_pkg::ID_W-1:0]    out_coarse_index,
  output logic                        out_paired,
  input  logic                        cfg_we,
  input  logic [gvm_pkg::SUM_W-1:0]   cfg_wdata
);

  gvm_pkg::ctl_cmd_t cmd;
  gvm_pkg::ctl_sts_t sts;

  // sequencing
  gvm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .busy      (busy)
  );

  // map, run state and result registers
  gvm_dp #(.NODE_COUNT(NODE_COUNT)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_node_id         (in_node_id),
    .in_node_weight     (in_node_weight),
    .in_has_neighbor    (in_has_neighbor),
    .in_neighbor_id     (in_neighbor_id),
    .in_neighbor_weight (in_neighbor_weight),
    .in_last_of_node    (in_last_of_node),
    .out_valid          (out_valid),
    .out_coarse_node    (out_coarse_node),
    .out_partner        (out_partner),
    .out_coarse_index   (out_coarse_index),
    .out_paired         (out_paired)
  );

endmodule
